FILE: rtl/core/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Used by every module of the block; depends on nothing else.
package wsdf_pkg;

   // Result kinds carried on the result channel's tuser.
   typedef enum logic [1:0] {
      EV_HEADER  = 2'd0,
      EV_PAYLOAD = 2'd1,
      EV_ERROR   = 2'd2
   } event_kind_type;

   localparam int BYTE_W   = 8;
   localparam int OPCODE_W = 4;
   localparam int LENGTH_W = 64;
   localparam int KIND_W   = 2;
   // payload_byte, frame_opcode, final_flag, masked_flag, payload_length = 78 bits
   localparam int FIELDS_W = BYTE_W + OPCODE_W + 1 + 1 + LENGTH_W;
   localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

   // One result item as it leaves the parser.
   typedef struct packed {
      event_kind_type        event_kind;
      logic [BYTE_W-1:0]     payload_byte;
      logic [OPCODE_W-1:0]   frame_opcode;
      logic                  final_flag;
      logic                  masked_flag;
      logic [LENGTH_W-1:0]   payload_length;
      logic                  last_of_frame;
   } rsp_type;

endpackage

FILE: rtl/core/websocket_frame_deframer_top.sv
// WebSocket frame deframer, top level.
// Bytes of a received frame stream enter on req_*, one item per byte.
// Results leave on rsp_*: tuser gives the kind (0 header complete,
// 1 payload byte, 2 reserved bits error), tlast marks the final result of a frame.
// tdata carries the unmasked payload byte, opcode, FIN, mask flag and the
// decoded 64-bit payload length of the current frame.
// A result passes from the input register through the parse logic into the
// result register. Throughput: one byte per cycle while a held result does not
// stall the result register; the parse step is a single pass of logic between
// the input register and the result register. Header bytes, length bytes and
// mask key bytes give no result except the byte that completes the header and
// a first header byte with reserved bits set, which gives the error result.
// After a reserved-bits error every byte is accepted and dropped until reset.
// Reset clears the parser to expect the first header byte and empties both
// registers. When the receiver holds rsp_tready low on a held result, the
// result register holds it and the input register takes one more byte, if it
// is empty, before req_tready drops.
// Depends on wsdf_pkg, wsdf_in_reg, wsdf_parser and wsdf_out_reg.
module websocket_frame_deframer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [wsdf_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [7:0] payload_byte, [11:8] frame_opcode, [12] final_flag,
   // [13] masked_flag, [77:14] payload_length, [79:78] zero
   output logic [wsdf_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [wsdf_pkg::KIND_W-1:0]  rsp_tuser,   // [1:0] event_kind
   output logic                         rsp_tlast    // last_of_frame
);
   import wsdf_pkg::*;

   logic              advance;
   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              res_valid;
   rsp_type           res;
   rsp_type           rsp;

   wsdf_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   wsdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (byte_valid && advance),
      .rx_byte   (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   wsdf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result fields, lowest field in the lowest bits.
   assign rsp_tdata = {{(TDATA_W-FIELDS_W){1'b0}}, rsp.payload_length, rsp.masked_flag,
                       rsp.final_flag, rsp.frame_opcode, rsp.payload_byte};
   assign rsp_tuser = rsp.event_kind;
   assign rsp_tlast = rsp.last_of_frame;

endmodule

FILE: rtl/core/wsdf_in_reg.sv
// Input register of the deframer: holds one received byte and its valid flag.
// Depends on wsdf_pkg.
module wsdf_in_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [wsdf_pkg::BYTE_W-1:0] req_tdata,
   input  logic                        advance,
   output logic                        byte_valid,
   output logic [wsdf_pkg::BYTE_W-1:0] byte_data
);
   import wsdf_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;

   // The register takes a new item when it is empty or moving on this cycle.
   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

FILE: rtl/core/wsdf_parser.sv
// Frame parser: header state, extended length, mask key and payload unmasking.
// Consumes one byte per step and produces at most one result. Depends on wsdf_pkg.
module wsdf_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [wsdf_pkg::BYTE_W-1:0] rx_byte,
   output logic                        res_valid,
   output wsdf_pkg::rsp_type           res
);
   import wsdf_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD,
      PH_ERROR
   } phase_type;

   localparam logic [BYTE_W-1:0] RSV_MASK = 8'h70;
   localparam logic [6:0]        LEN_EXT16 = 7'd126;
   localparam logic [6:0]        LEN_EXT64 = 7'd127;
   localparam logic [3:0]        EXT16_BYTES = 4'd2;
   localparam logic [3:0]        EXT64_BYTES = 4'd8;
   localparam logic [3:0]        KEY_BYTES   = 4'd4;

   phase_type           phase_ff, phase_in;
   logic                fin_ff, fin_in;
   logic [OPCODE_W-1:0] opc_ff, opc_in;
   logic                mask_on_ff, mask_on_in;
   logic [LENGTH_W-1:0] len_ff, len_in;
   logic [3:0]          left_ff, left_in;
   logic [31:0]         key_ff, key_in;
   // Holds the payload position plus one, so the last-byte test is a plain compare.
   logic [LENGTH_W-1:0] pos_inc_ff, pos_inc_in;
   logic [1:0]          kidx_ff, kidx_in;

   logic              hdr_done;
   logic              emit;
   event_kind_type    kind;
   logic [BYTE_W-1:0] out_byte;
   logic              last;
   logic [BYTE_W-1:0] key_byte;

   // Key byte for the current payload position, most significant byte first.
   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Next state and result for the byte at the parser input.
   always_comb begin
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      opc_in     = opc_ff;
      mask_on_in = mask_on_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      key_in     = key_ff;
      pos_inc_in = pos_inc_ff;
      kidx_in    = kidx_ff;
      hdr_done   = 1'b0;
      emit       = 1'b0;
      kind       = EV_HEADER;
      out_byte   = '0;
      last       = 1'b0;

      case (phase_ff)
         PH_HDR0: begin
            fin_in = rx_byte[7];
            opc_in = rx_byte[OPCODE_W-1:0];
            if ((rx_byte & RSV_MASK) != '0) begin
               mask_on_in = 1'b0;
               len_in     = '0;
               phase_in   = PH_ERROR;
               emit       = 1'b1;
               kind       = EV_ERROR;
               last       = 1'b1;
            end else begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1: begin
            mask_on_in = rx_byte[7];
            if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
               len_in   = '0;
               left_in  = (rx_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               phase_in = PH_EXTLEN;
            end else begin
               len_in = {{(LENGTH_W-7){1'b0}}, rx_byte[6:0]};
               if (rx_byte[7]) begin
                  left_in  = KEY_BYTES;
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
               end
            end
         end
         PH_EXTLEN: begin
            len_in  = {len_ff[LENGTH_W-BYTE_W-1:0], rx_byte};
            left_in = left_ff - 4'd1;
            if (left_in == 4'd0) begin
               if (mask_on_ff) begin
                  left_in  = KEY_BYTES;
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in  = {key_ff[23:0], rx_byte};
            left_in = left_ff - 4'd1;
            if (left_in == 4'd0) begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            out_byte   = mask_on_ff ? (rx_byte ^ key_byte) : rx_byte;
            kidx_in    = kidx_ff + 2'd1;
            pos_inc_in = pos_inc_ff + 64'd1;
            last       = (pos_inc_ff >= len_ff);
            emit       = 1'b1;
            kind       = EV_PAYLOAD;
            if (last) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            // Error state: bytes are taken and dropped until reset.
         end
      endcase

      // Header complete: an empty payload closes the frame right here.
      if (hdr_done) begin
         pos_inc_in = 64'd1;
         kidx_in    = 2'd0;
         last       = (len_in == '0);
         phase_in   = last ? PH_HDR0 : PH_PAYLOAD;
         emit       = 1'b1;
         kind       = EV_HEADER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         fin_ff     <= 1'b0;
         opc_ff     <= '0;
         mask_on_ff <= 1'b0;
         len_ff     <= '0;
         left_ff    <= '0;
         key_ff     <= '0;
         pos_inc_ff <= '0;
         kidx_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opc_ff     <= opc_in;
         mask_on_ff <= mask_on_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
         key_ff     <= key_in;
         pos_inc_ff <= pos_inc_in;
         kidx_ff    <= kidx_in;
      end
   end

   // The result always reflects the frame state after this byte.
   assign res_valid          = step && emit;
   assign res.event_kind     = kind;
   assign res.payload_byte   = out_byte;
   assign res.frame_opcode   = opc_in;
   assign res.final_flag     = fin_in;
   assign res.masked_flag    = mask_on_in;
   assign res.payload_length = len_in;
   assign res.last_of_frame  = last;

endmodule

FILE: rtl/core/wsdf_out_reg.sv
// Result register of the deframer: holds one finished result until it is taken.
// Depends on wsdf_pkg.
module wsdf_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_valid,
   input  wsdf_pkg::rsp_type res,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wsdf_pkg::rsp_type rsp
);
   import wsdf_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The pipeline moves whenever this register is empty or being drained.
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

FILE: rtl/core/wsdf_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsdf_pkg and websocket_frame_deframer_top.
module wsdf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [wsdf_pkg::TDATA_W-1:0] rsp_tdata,
   input logic [wsdf_pkg::KIND_W-1:0]  rsp_tuser,
   input logic                         rsp_tlast
);
   import wsdf_pkg::*;

   // A stalled result stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its contents.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // An error result always closes the frame and carries no length.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ERROR |-> rsp_tlast && rsp_tdata[77:14] == '0)
      else $error("error result malformed");

   // A header with an empty payload closes the frame.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_HEADER && rsp_tdata[77:14] == '0 |-> rsp_tlast)
      else $error("empty frame header not marked last");

   // Only payload results carry a data byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_PAYLOAD |-> rsp_tdata[7:0] == '0)
      else $error("non-payload result carries a byte");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
